// File: rtl/core/cdeq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque package
// Shared constants, operation and status codes, and the request and
// response payload types of the circular double-ended queue.
// ----------------------------------------------------------------------------
package cdeq_pkg;

  localparam int DEPTH = 1024;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int KIND_W = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 11;

  localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_HEAD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_TAIL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_HEAD  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP_TAIL  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] tail_value;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/cdeq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque channels
// Valid/ready channels that carry request and response transactions.
// ----------------------------------------------------------------------------
interface cdeq_req_if;
  logic            valid;
  logic            ready;
  cdeq_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cdeq_rsp_if;
  logic            valid;
  logic            ready;
  cdeq_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/circular_double_ended_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Circular double-ended queue
// Deque of signed 32-bit entries in a single-port-read synchronous memory.
// ----------------------------------------------------------------------------
// Each request transaction yields one response transaction. The entries live
// in a memory with one write and one registered read port; the values at the
// head and the tail are also held in registers. Queries, pushes, rejected
// operations and a pop that empties the queue produce their response in the
// cycle after acceptance. A pop that leaves entries behind passes through
// ST_READ, as the new end value is fetched through the memory read port.
// Pushes and queries sustain one transaction per cycle while responses are
// taken; such a pop holds off new requests until its read is done. The
// response is held in an output register, and a new request is accepted
// while it is being taken. The memory needs no clearing after reset.
module circular_double_ended_queue_top (
  input  wire logic  clk,
  input  wire logic  rst,
  cdeq_req_if.sink   req,
  cdeq_rsp_if.source rsp
);

  typedef logic [cdeq_pkg::IDX_W-1:0] idx_t;
  typedef logic [cdeq_pkg::CNT_W-1:0] cnt_t;
  typedef logic signed [cdeq_pkg::DATA_W-1:0] data_t;

  function automatic idx_t slot_inc(input idx_t p);
    return (p == idx_t'(cdeq_pkg::DEPTH - 1)) ? '0 : idx_t'(p + 1'b1);
  endfunction

  function automatic idx_t slot_dec(input idx_t p);
    return (p == '0) ? idx_t'(cdeq_pkg::DEPTH - 1) : idx_t'(p - 1'b1);
  endfunction

  data_t mem [cdeq_pkg::DEPTH];
  data_t rdata;

  cdeq_pkg::state_t state, state_next;
  idx_t  head_idx, head_idx_next;
  idx_t  tail_idx, tail_idx_next;
  cnt_t  count, count_next;
  data_t head_val, head_val_next;
  data_t tail_val, tail_val_next;
  logic  pend_head, pend_head_next;
  logic  rsp_valid, rsp_valid_next;
  cdeq_pkg::rsp_t res, res_next;

  logic  accept;
  logic  mem_we;
  idx_t  waddr;
  data_t wdata;
  logic  mem_re;
  idx_t  raddr;

  assign rsp.valid = rsp_valid;
  assign rsp.data  = res;
  assign req.ready = (state == cdeq_pkg::ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cdeq_pkg::ST_IDLE;
      head_idx  <= '0;
      tail_idx  <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head_idx  <= head_idx_next;
      tail_idx  <= tail_idx_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    head_val  <= head_val_next;
    tail_val  <= tail_val_next;
    pend_head <= pend_head_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    head_idx_next  = head_idx;
    tail_idx_next  = tail_idx;
    count_next     = count;
    head_val_next  = head_val;
    tail_val_next  = tail_val;
    pend_head_next = pend_head;
    rsp_valid_next = rsp_valid && !rsp.ready;
    res_next       = res;
    mem_we         = 1'b0;
    waddr          = '0;
    wdata          = req.data.push_value;
    mem_re         = 1'b0;
    raddr          = '0;

    unique case (state)
      cdeq_pkg::ST_IDLE: begin
        if (accept) begin
          res_next.popped_value = '0;
          res_next.status       = cdeq_pkg::STAT_OK;
          unique case (req.data.kind)
            cdeq_pkg::KIND_PUSH_HEAD: begin
              if (count == cnt_t'(cdeq_pkg::DEPTH)) begin
                res_next.status = cdeq_pkg::STAT_FULL;
              end else begin
                head_idx_next = slot_dec(head_idx);
                mem_we        = 1'b1;
                waddr         = slot_dec(head_idx);
                head_val_next = req.data.push_value;
                if (count == '0) begin
                  tail_val_next = req.data.push_value;
                end
                count_next = cnt_t'(count + 1'b1);
              end
            end
            cdeq_pkg::KIND_PUSH_TAIL: begin
              if (count == cnt_t'(cdeq_pkg::DEPTH)) begin
                res_next.status = cdeq_pkg::STAT_FULL;
              end else begin
                tail_idx_next = slot_inc(tail_idx);
                mem_we        = 1'b1;
                waddr         = tail_idx;
                tail_val_next = req.data.push_value;
                if (count == '0) begin
                  head_val_next = req.data.push_value;
                end
                count_next = cnt_t'(count + 1'b1);
              end
            end
            cdeq_pkg::KIND_POP_HEAD: begin
              if (count == '0) begin
                res_next.status = cdeq_pkg::STAT_EMPTY;
              end else begin
                res_next.popped_value = head_val;
                head_idx_next         = slot_inc(head_idx);
                count_next            = cnt_t'(count - 1'b1);
                if (count > cnt_t'(1)) begin
                  mem_re         = 1'b1;
                  raddr          = slot_inc(head_idx);
                  pend_head_next = 1'b1;
                  state_next     = cdeq_pkg::ST_READ;
                end
              end
            end
            cdeq_pkg::KIND_POP_TAIL: begin
              if (count == '0) begin
                res_next.status = cdeq_pkg::STAT_EMPTY;
              end else begin
                res_next.popped_value = tail_val;
                tail_idx_next         = slot_dec(tail_idx);
                count_next            = cnt_t'(count - 1'b1);
                if (count > cnt_t'(1)) begin
                  mem_re         = 1'b1;
                  raddr          = slot_dec(slot_dec(tail_idx));
                  pend_head_next = 1'b0;
                  state_next     = cdeq_pkg::ST_READ;
                end
              end
            end
            default: begin
            end
          endcase
          res_next.occupancy  = cdeq_pkg::OCC_W'(count_next);
          res_next.is_empty   = (count_next == '0);
          res_next.head_value = (count_next == '0) ? '0 : head_val_next;
          res_next.tail_value = (count_next == '0) ? '0 : tail_val_next;
          rsp_valid_next      = (state_next == cdeq_pkg::ST_IDLE);
        end
      end
      cdeq_pkg::ST_READ: begin
        if (pend_head) begin
          head_val_next       = rdata;
          res_next.head_value = rdata;
        end else begin
          tail_val_next       = rdata;
          res_next.tail_value = rdata;
        end
        rsp_valid_next = 1'b1;
        state_next     = cdeq_pkg::ST_IDLE;
      end
      default: begin
        state_next = cdeq_pkg::ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(cdeq_pkg::DEPTH))
    else $error("Occupancy exceeds the queue depth.");

  a_read_completes: assert property (@(posedge clk) disable iff (rst)
    state == cdeq_pkg::ST_READ |=> rsp.valid && state == cdeq_pkg::ST_IDLE)
    else $error("Refill read did not produce a response transaction.");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.data.is_empty == (rsp.data.occupancy == '0)))
    else $error("Empty flag disagrees with occupancy.");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    accept && count == '0 &&
    (req.data.kind == cdeq_pkg::KIND_POP_HEAD || req.data.kind == cdeq_pkg::KIND_POP_TAIL)
    |=> rsp.valid && rsp.data.status == cdeq_pkg::STAT_EMPTY)
    else $error("Pop on an empty queue was not reported.");

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular double-ended queue testbench
// Drives request transactions into the deque and checks every response
// against a behavioral deque kept alongside, or against the expected values
// of a short table of directed operations that covers reset, the value
// extremes, pops on an empty queue and unused operation codes. Random
// phases then wander near empty, fill the queue past full, and drain part
// of it again, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb;
  import cdeq_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam int MIX_ITEMS = 40;
  localparam int DRAIN_ITEMS = 100;
  localparam int FULL_PUSHES = 8;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    rsp_t                     want;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  cdeq_req_if req_ch ();
  cdeq_rsp_if rsp_ch ();

  circular_double_ended_queue_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic signed [DATA_W-1:0] shadow_mem [DEPTH];
  int   shadow_head;
  int   shadow_tail;
  int   shadow_count;

  rsp_t pending_rsp [$];
  row_t dir_rows [$];
  int   fail_cnt;
  int   cycle_cnt;
  int   sent_cnt;
  int   taken_cnt;
  bit   send_rush;
  bit   take_rush;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic rsp_t deque_step(input logic [KIND_W-1:0] kind,
                                      input logic signed [DATA_W-1:0] value);
    rsp_t r;
    r = '0;
    r.status = STAT_OK;
    case (kind)
      KIND_PUSH_HEAD, KIND_PUSH_TAIL: begin
        if (shadow_count == DEPTH) begin
          r.status = STAT_FULL;
        end else if (kind == KIND_PUSH_HEAD) begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_mem[IDX_W'(shadow_head)] = value;
          shadow_count++;
        end else begin
          shadow_mem[IDX_W'(shadow_tail)] = value;
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_count++;
        end
      end
      KIND_POP_HEAD, KIND_POP_TAIL: begin
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
        end else if (kind == KIND_POP_HEAD) begin
          r.popped_value = shadow_mem[IDX_W'(shadow_head)];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end else begin
          shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
          r.popped_value = shadow_mem[IDX_W'(shadow_tail)];
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    r.occupancy = OCC_W'(shadow_count);
    r.is_empty = (shadow_count == 0);
    if (shadow_count != 0) begin
      r.head_value = shadow_mem[IDX_W'(shadow_head)];
      r.tail_value = shadow_mem[IDX_W'((shadow_tail + DEPTH - 1) % DEPTH)];
    end
    return r;
  endfunction

  task automatic add_row(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] value,
                         input bit typed, input logic signed [DATA_W-1:0] popped,
                         input logic [STAT_W-1:0] status, input int occ,
                         input logic signed [DATA_W-1:0] headv,
                         input logic signed [DATA_W-1:0] tailv);
    row_t row;
    row.kind = kind;
    row.value = value;
    row.typed = typed;
    row.want.popped_value = popped;
    row.want.status = status;
    row.want.occupancy = OCC_W'(occ);
    row.want.is_empty = (occ == 0);
    row.want.head_value = headv;
    row.want.tail_value = tailv;
    dir_rows.push_back(row);
  endtask

  function automatic int idle_gap(input bit rush);
    return rush ? 0 : $urandom_range(16, 0);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(7, 0))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] rand_push();
    return ($urandom_range(1, 0) == 0) ? KIND_PUSH_HEAD : KIND_PUSH_TAIL;
  endfunction

  function automatic logic [KIND_W-1:0] rand_pop();
    return ($urandom_range(1, 0) == 0) ? KIND_POP_HEAD : KIND_POP_TAIL;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic signed [DATA_W-1:0] value,
                           input bit typed, input rsp_t want);
    int   gap;
    rsp_t predicted;
    if (sent_cnt % 50 == 0) begin
      send_rush = ($urandom_range(2, 0) == 0);
    end
    gap = idle_gap(send_rush);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data.kind <= kind;
    req_ch.data.push_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = deque_step(kind, value);
    pending_rsp.push_back(typed ? want : predicted);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  initial begin
    int   gap;
    rsp_t want;
    wait (rst === 1'b0);
    forever begin
      if (taken_cnt % 50 == 0) begin
        take_rush = ($urandom_range(2, 0) == 0);
      end
      gap = idle_gap(take_rush);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      taken_cnt++;
      if (pending_rsp.size() == 0) begin
        $error("response transaction with no expectation pending");
        fail_cnt++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("popped_value", longint'(want.popped_value),
                    longint'(rsp_ch.data.popped_value));
        check_field("status", longint'(want.status), longint'(rsp_ch.data.status));
        check_field("occupancy", longint'(want.occupancy),
                    longint'(rsp_ch.data.occupancy));
        check_field("is_empty", longint'(want.is_empty), longint'(rsp_ch.data.is_empty));
        check_field("head_value", longint'(want.head_value),
                    longint'(rsp_ch.data.head_value));
        check_field("tail_value", longint'(want.tail_value),
                    longint'(rsp_ch.data.tail_value));
      end
      @(negedge clk);
    end
  end

  initial begin
    wait (cycle_cnt >= MAX_CYCLES);
    $display("tb failed");
    $finish;
  end

  initial begin
    rsp_t none;
    logic [KIND_W-1:0] kind;
    none = '0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cycle_cnt = 0;
    fail_cnt = 0;
    sent_cnt = 0;
    taken_cnt = 0;
    send_rush = 1'b0;
    take_rush = 1'b0;
    shadow_head = 0;
    shadow_tail = 0;
    shadow_count = 0;

    add_row(KIND_QUERY,     0,               1, 0, STAT_OK,    0, 0, 0);
    add_row(KIND_POP_HEAD,  0,               1, 0, STAT_EMPTY, 0, 0, 0);
    add_row(KIND_POP_TAIL,  -1,              1, 0, STAT_EMPTY, 0, 0, 0);
    add_row(3'd7,           32'sh1234_5678,  1, 0, STAT_OK,    0, 0, 0);
    add_row(KIND_PUSH_TAIL, 32'sh7fff_ffff,  1, 0, STAT_OK,    1,
            32'sh7fff_ffff, 32'sh7fff_ffff);
    add_row(KIND_PUSH_HEAD, 32'sh8000_0000,  1, 0, STAT_OK,    2,
            32'sh8000_0000, 32'sh7fff_ffff);
    add_row(KIND_QUERY,     -1,              1, 0, STAT_OK,    2,
            32'sh8000_0000, 32'sh7fff_ffff);
    add_row(KIND_POP_TAIL,  0,               1, 32'sh7fff_ffff, STAT_OK, 1,
            32'sh8000_0000, 32'sh8000_0000);
    add_row(KIND_POP_HEAD,  0,               1, 32'sh8000_0000, STAT_OK, 0, 0, 0);
    add_row(KIND_PUSH_HEAD, -1,              1, 0, STAT_OK,    1, -1, -1);
    add_row(KIND_PUSH_TAIL, 0,               0, 0, STAT_OK,    0, 0, 0);
    add_row(KIND_PUSH_HEAD, 1,               0, 0, STAT_OK,    0, 0, 0);
    add_row(3'd5,           32'sh7fff_ffff,  0, 0, STAT_OK,    0, 0, 0);
    add_row(3'd6,           32'sh8000_0000,  0, 0, STAT_OK,    0, 0, 0);
    add_row(KIND_POP_HEAD,  0,               0, 0, STAT_OK,    0, 0, 0);
    add_row(KIND_POP_TAIL,  0,               0, 0, STAT_OK,    0, 0, 0);
    add_row(KIND_PUSH_TAIL, 32'sh5555_5555,  0, 0, STAT_OK,    0, 0, 0);
    add_row(KIND_PUSH_TAIL, 32'shaaaa_aaaa,  0, 0, STAT_OK,    0, 0, 0);
    add_row(KIND_POP_HEAD,  0,               0, 0, STAT_OK,    0, 0, 0);
    add_row(KIND_POP_HEAD,  0,               0, 0, STAT_OK,    0, 0, 0);
    add_row(KIND_POP_TAIL,  0,               0, 0, STAT_OK,    0, 0, 0);
    add_row(KIND_POP_TAIL,  0,               1, 0, STAT_EMPTY, 0, 0, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
    end

    req_ch.valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    @(negedge clk);

    repeat (MIX_ITEMS) begin
      send_item(KIND_W'($urandom_range(7, 0)), rand_value(), 1'b0, none);
    end

    while (shadow_count < DEPTH) begin
      kind = ($urandom_range(19, 0) == 0) ? KIND_W'($urandom_range(7, 0)) : rand_push();
      send_item(kind, rand_value(), 1'b0, none);
    end
    repeat (FULL_PUSHES) begin
      send_item(rand_push(), rand_value(), 1'b0, none);
    end

    req_ch.valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    @(negedge clk);

    repeat (DRAIN_ITEMS) begin
      kind = ($urandom_range(4, 0) == 0) ? KIND_W'($urandom_range(7, 0)) : rand_pop();
      send_item(kind, rand_value(), 1'b0, none);
    end

    repeat (MIX_ITEMS) begin
      send_item(KIND_W'($urandom_range(7, 0)), rand_value(), 1'b0, none);
    end

    req_ch.valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (8) @(posedge clk);

    if (pending_rsp.size() != 0) begin
      $error("%0d expected responses never arrived", pending_rsp.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
